/* src/base64_stream_decoder_defines.svh */
// Assertion macros shared by the base64 decoder modules.
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define B64D_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/b64d_pkg.sv */
// Types, constants and the character classifier of the base64 decoder.
package b64d_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	localparam logic [1:0] SLOT_0 = 2'd0;
	localparam logic [1:0] SLOT_1 = 2'd1;
	localparam logic [1:0] SLOT_2 = 2'd2;
	localparam logic [1:0] LAST_CHAR = 2'd3;

	typedef struct packed {
		logic       bad;
		logic [5:0] idx;
	} b64d_class_t;

	// One completed group: three candidate bytes and which optional ones go out.
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic       emit1;
		logic       emit2;
	} b64d_group_t;

	function automatic b64d_class_t classify(input logic [7:0] c);
		b64d_class_t r;
		r.bad = 1'b0;
		r.idx = 6'd0;
		priority if (c >= 8'h41 && c <= 8'h5A) begin
			r.idx = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r.idx = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r.idx = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			r.idx = 6'd62;
		end else if (c == 8'h2F) begin
			r.idx = 6'd63;
		end else if (c == PAD_CHAR) begin
			r.idx = 6'd0;
		end else begin
			r.bad = 1'b1;
		end
		return r;
	endfunction

endpackage

/* src/b64d_front.sv */
// Front end: classifies characters, gathers groups of four, queues finished groups.
`include "base64_stream_decoder_defines.svh"

module b64d_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [7:0]           char_code,
	input  logic                 end_of_text,
	output logic                 grp_push,
	output b64d_pkg::b64d_group_t grp_data,
	input  logic                 grp_full
);
	import b64d_pkg::*;

	logic [5:0]  held_q [3];
	logic [1:0]  count_q;
	logic        invalid_q;
	logic        third_pad_q;
	logic        accept;
	logic        is_pad;
	logic        group_done;
	b64d_class_t cls;

	assign cls        = classify(char_code);
	assign is_pad     = (char_code == PAD_CHAR);
	assign group_done = (count_q == LAST_CHAR);
	// only the closing character of a group needs room in the queue
	assign full       = grp_full & group_done;
	assign accept     = push & ~full;
	assign grp_push   = accept & group_done & ~(invalid_q | cls.bad);

	always_comb begin
		grp_data.b0    = {held_q[0], held_q[1][5:4]};
		grp_data.b1    = {held_q[1][3:0], held_q[2][5:2]};
		grp_data.b2    = {held_q[2][1:0], cls.idx};
		grp_data.emit1 = ~third_pad_q;
		grp_data.emit2 = ~is_pad;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (count_q)
				SLOT_0:    held_q[0] <= cls.idx;
				SLOT_1:    held_q[1] <= cls.idx;
				SLOT_2:    held_q[2] <= cls.idx;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= 2'd0;
			invalid_q   <= 1'b0;
			third_pad_q <= 1'b0;
		end else if (accept) begin
			if (group_done || end_of_text) begin
				count_q     <= 2'd0;
				invalid_q   <= 1'b0;
				third_pad_q <= 1'b0;
			end else begin
				count_q   <= count_q + 2'd1;
				invalid_q <= invalid_q | cls.bad;
				if (count_q == SLOT_2) begin
					third_pad_q <= is_pad;
				end
			end
		end
	end

	`B64D_ASSERT_NEXT(a_eot_clears, accept && end_of_text, count_q == 2'd0 && !invalid_q, "end of text left a partial group")
	`B64D_ASSERT_IMPL(a_push_room, grp_push, !grp_full, "group pushed into a full queue")

endmodule

/* src/b64d_queue.sv */
// Short queue of finished groups between the front and back ends.
`include "base64_stream_decoder_defines.svh"

module b64d_queue #(
	parameter int DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  b64d_pkg::b64d_group_t wdata,
	output logic                  full,
	input  logic                  pop,
	output b64d_pkg::b64d_group_t rdata,
	output logic                  empty
);
	import b64d_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	b64d_group_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`B64D_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

/* src/b64d_back.sv */
// Back end: walks each queued group and sends its bytes out one request at a time.
`include "base64_stream_decoder_defines.svh"

module b64d_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  b64d_pkg::b64d_group_t grp_data,
	input  logic                  grp_empty,
	output logic                  grp_pop,
	output logic                  empty,
	input  logic                  pop,
	output logic [7:0]            data_byte,
	output logic [1:0]            byte_slot,
	output logic                  group_end
);
	import b64d_pkg::*;

	b64d_group_t cur_q;
	logic        cur_valid_q;
	logic [1:0]  slot_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic [1:0]  out_slot_q;
	logic        out_end_q;
	logic        out_ready;
	logic        emit;
	logic        cur_last;
	logic [1:0]  nxt_slot;
	logic [7:0]  sel_byte;

	assign out_ready = ~out_valid_q | pop;
	assign emit      = cur_valid_q & out_ready;
	assign grp_pop   = ~grp_empty & (~cur_valid_q | (emit & cur_last));

	always_comb begin
		cur_last = 1'b1;
		nxt_slot = SLOT_2;
		sel_byte = '0;
		unique case (slot_q)
			SLOT_0: begin
				cur_last = ~cur_q.emit1 & ~cur_q.emit2;
				nxt_slot = cur_q.emit1 ? SLOT_1 : SLOT_2;
				sel_byte = cur_q.b0;
			end
			SLOT_1: begin
				cur_last = ~cur_q.emit2;
				sel_byte = cur_q.b1;
			end
			SLOT_2: begin
				sel_byte = cur_q.b2;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (grp_pop) begin
			cur_q <= grp_data;
		end
		if (emit) begin
			out_byte_q <= sel_byte;
			out_slot_q <= slot_q;
			out_end_q  <= cur_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			slot_q      <= SLOT_0;
			out_valid_q <= 1'b0;
		end else begin
			// load the next group as the current one drains
			if (grp_pop) begin
				cur_valid_q <= 1'b1;
				slot_q      <= SLOT_0;
			end else if (emit && cur_last) begin
				cur_valid_q <= 1'b0;
			end else if (emit) begin
				slot_q <= nxt_slot;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty     = ~out_valid_q;
	assign data_byte = out_byte_q;
	assign byte_slot = out_slot_q;
	assign group_end = out_end_q;

	`B64D_ASSERT_IMPL(a_slot2_wanted, cur_valid_q && slot_q == SLOT_2, cur_q.emit2, "slot 2 reached on a padded group")
	`B64D_ASSERT_IMPL(a_slot1_wanted, cur_valid_q && slot_q == SLOT_1, cur_q.emit1, "slot 1 reached on a padded group")
	`B64D_ASSERT_IMPL(a_out_slot, out_valid_q, out_slot_q != LAST_CHAR, "output carries slot 3")

endmodule

/* src/base64_stream_decoder.sv */
// Top level of the streaming base64 decoder.
// Takes one base64 character per cycle while full is low and returns decoded bytes with
// their slot in the group and a mark on the group's last byte; '=' counts as zero and
// suppresses slot 1 or 2 when it stands third or fourth, a group with any invalid
// character yields nothing, and end_of_text drops a partial group. A finished group is
// written into the group queue, then into the back end's current group, then into
// the output register; bytes go out one per cycle while pop keeps up, so at most
// three bytes per four characters keep pace with the input. full rises only on the fourth
// character of a group while the group queue of QUEUE_DEPTH entries is full.
module base64_stream_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_code,
	input  logic       end_of_text,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] data_byte,
	output logic [1:0] byte_slot,
	output logic       group_end
);
	import b64d_pkg::*;

	b64d_group_t grp_wdata;
	b64d_group_t grp_rdata;
	logic        grp_push;
	logic        grp_full;
	logic        grp_pop;
	logic        grp_empty;

	b64d_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.grp_push    (grp_push),
		.grp_data    (grp_wdata),
		.grp_full    (grp_full)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (grp_push),
		.wdata  (grp_wdata),
		.full   (grp_full),
		.pop    (grp_pop),
		.rdata  (grp_rdata),
		.empty  (grp_empty)
	);

	b64d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_data  (grp_rdata),
		.grp_empty (grp_empty),
		.grp_pop   (grp_pop),
		.empty     (empty),
		.pop       (pop),
		.data_byte (data_byte),
		.byte_slot (byte_slot),
		.group_end (group_end)
	);

endmodule
